@@ src/count_ordered_self_organizing_table_assert.svh @@
`ifndef COUNT_ORDERED_SELF_ORGANIZING_TABLE_ASSERT_SVH
`define COUNT_ORDERED_SELF_ORGANIZING_TABLE_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication under synchronous active-low reset
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

@@ src/cosot_pkg.sv @@
package cosot_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int KEY_W       = 32;
    localparam int POS_W       = 4;
    localparam int HIT_COUNT_W = 16;
    localparam int SIZE_W      = 5;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

@@ src/count_ordered_self_organizing_table.sv @@
// Count-ordered self-organising table. The keys and their hit counts live in one
// single-port-read, single-port-write RAM with a registered read, so every operation
// walks the table one entry per cycle and one item is processed at a time. An insert
// into a table holding n entries shifts them back by one and places the new key at
// the head; an insert into a full table is rejected. A search that hits at position
// h moves the entry forward d places, over entries whose count is below its new one;
// a miss scans all n entries. A new word is taken as soon as the previous result has
// been loaded into the output register, whether or not it has been collected.
module count_ordered_self_organizing_table #(
    parameter int ENTRIES    = cosot_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = cosot_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cosot_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // key
    input  logic [cosot_pkg::IN_USER_W-1:0]  s_axis_tuser,  // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // found, accepted, position, hit_count, size, empty_res, zero fill
    output logic [cosot_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import cosot_pkg::*;

    `include "count_ordered_self_organizing_table_assert.svh"

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ENT_W = KEY_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
    localparam int FILL_W = OUT_DATA_W - (3 + POS_W + HIT_COUNT_W + SIZE_W);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_START  = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_MOVE   = 6'b001000,
        ST_PLACE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic                  func_reg, func_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [COUNT_BITS-1:0] c_reg, c_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  found_reg, found_next;
    logic                  acc_reg, acc_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  do_move;

    cosot_ram #(
        .WIDTH(ENT_W),
        .DEPTH(ENTRIES)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_key  = ram_rdata[ENT_W-1 -: KEY_W];
    assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
    assign do_move = (func_reg == OP_INSERT) || (rd_cnt < c_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        key_next     = key_reg;
        c_next       = c_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = ptr_reg;
        ram_wdata    = {key_reg, c_reg};
        ram_raddr    = '0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    func_next  = s_axis_tuser[0];
                    key_next   = s_axis_tdata[KEY_W-1:0];
                    state_next = ST_START;
                end
            end
            ST_START: begin
                found_next = 1'b0;
                acc_next   = 1'b0;
                c_next     = '0;
                ptr_next   = '0;
                if (func_reg == OP_INSERT) begin
                    if (count_reg == CNT_W'(ENTRIES)) begin
                        state_next = ST_FINISH;
                    end else if (count_reg == '0) begin
                        acc_next   = 1'b1;
                        state_next = ST_PLACE;
                    end else begin
                        acc_next   = 1'b1;
                        ram_raddr  = IDX_W'(count_reg - 1'b1);
                        ptr_next   = IDX_W'(count_reg);
                        state_next = ST_MOVE;
                    end
                end else begin
                    if (count_reg == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_key == key_reg) begin
                    found_next = 1'b1;
                    c_next     = (rd_cnt == CountMax) ? rd_cnt : rd_cnt + 1'b1;
                    if (ptr_reg == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        ram_raddr  = ptr_reg - 1'b1;
                        state_next = ST_MOVE;
                    end
                end else if (CNT_W'(ptr_reg) == count_reg - 1'b1) begin
                    ptr_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    ram_raddr = ptr_reg + 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
            end
            ST_MOVE: begin
                ram_we = 1'b1;
                if (do_move) begin
                    ram_wdata = ram_rdata;
                    if (ptr_reg == IDX_W'(1)) begin
                        ptr_next   = '0;
                        state_next = ST_PLACE;
                    end else begin
                        ram_raddr = ptr_reg - IDX_W'(2);
                        ptr_next  = ptr_reg - 1'b1;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_PLACE: begin
                ram_we = 1'b1;
                if (func_reg == OP_INSERT) begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{FILL_W{1'b0}}, (count_reg == '0),
                                    SIZE_W'(count_reg), HIT_COUNT_W'(c_reg),
                                    POS_W'(ptr_reg), acc_reg, found_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg   <= func_next;
        key_reg    <= key_next;
        c_reg      <= c_next;
        ptr_reg    <= ptr_next;
        found_reg  <= found_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    `ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(ENTRIES))
    `ASSERT_IMPLIES(a_move_not_head, aclk, aresetn, state_reg == ST_MOVE, ptr_reg != '0)
    `ASSERT_IMPLIES(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN,
                    CNT_W'(ptr_reg) < count_reg)
    `ASSERT_NEXT(a_result_kind, aclk, aresetn, state_reg == ST_FINISH,
                 !(m_data_reg[0] && m_data_reg[1]))

endmodule

@@ src/cosot_ram.sv @@
module cosot_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
